// ===== hdl/wmf_pkg.sv =====
// Shared types and constants of the window median filter.
// No dependencies; used by the interfaces, the top level and the testbench.
`default_nettype none

package wmf_pkg;

    localparam int PIXEL_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int WSIZE_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_EMIT
    } wmf_state_t;

endpackage

`default_nettype wire

// ===== hdl/wmf_pix_if.sv =====
// Input pixel channel: valid/ready handshake with the pixel request payload.
// Depends on wmf_pkg.
`default_nettype none

interface wmf_pix_if import wmf_pkg::*;;
    logic               valid;
    logic               ready;
    logic               func;
    logic [PIXEL_W-1:0] pixel_value;

    modport source (output valid, output func, output pixel_value, input ready);
    modport sink   (input valid, input func, input pixel_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/wmf_res_if.sv =====
// Result channel: valid/ready handshake carrying one median request.
// Depends on wmf_pkg.
`default_nettype none

interface wmf_res_if import wmf_pkg::*;;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] median_value;
    logic               run_last;
    logic               frame_last;

    modport source (output valid, output median_value, output run_last,
                    output frame_last, input ready);
    modport sink   (input valid, input median_value, input run_last,
                    input frame_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/wmf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module wmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4608
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/window_median_filter.sv =====
// Streaming N x N median filter (N odd, 3..MAX_WINDOW) over 8-bit raster pixels with
// replicated borders. Pixels are written into a line store RAM of MAX_WINDOW rows; each
// output median is found by an 8-pass radix select that re-reads the N*N window from
// that RAM, one pixel per cycle, each pass closing with a drain step. An input causing
// no output leaves the input ready; the last pixel of a row can cause up to N/2 + 1
// outputs. The input is held off while outputs of the current pixel are being computed
// or waiting. Depends on wmf_pkg, wmf_pix_if, wmf_res_if and wmf_ram.
`default_nettype none

module window_median_filter import wmf_pkg::*; #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_WINDOW = 9
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    wmf_pix_if.sink                    pix,
    wmf_res_if.source                  res
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT + MAX_WINDOW);
    localparam int SW    = ((CW > RW) ? CW : RW) + 2;
    localparam int NW    = $clog2(MAX_WINDOW + 1);
    localparam int SLW   = $clog2(MAX_WINDOW);
    localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);

    wmf_state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] width_reg, height_reg;
    logic [WSIZE_W-1:0]    wsize_reg;
    logic [CW-1:0]         col_reg, col_next;
    logic [RW-1:0]         row_reg, row_next;
    logic [SLW-1:0]        slot_reg, slot_next;

    logic signed [SW-1:0]  r_reg, r_next, k_reg, k_next;
    logic signed [SW-1:0]  oc_reg, oc_next, last_reg, last_next;
    logic [SLW-1:0]        kslot_reg, kslot_next;
    logic [NW-1:0]         dy_reg, dy_next, dx_reg, dx_next;
    logic                  rd_vld_reg;
    logic [2:0]            bit_reg, bit_next;
    logic [PIXEL_W-1:0]    prefix_reg, prefix_next;
    logic [KW-1:0]         rank_reg, rank_next, cnt0_reg, cnt0_next;

    logic signed [SW-1:0]  w_eff, h_eff, p_eff;
    logic [NW-1:0]         n_eff;
    logic [KW-1:0]         cnt_total;

    logic                  accept, has_out, pass_done, read_last, emit_done;
    logic signed [SW-1:0]  c_cur, k_cur, first_oc, last_oc;
    logic [SLW-1:0]        slot_cur;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [PIXEL_W-1:0]    mem_wdata, mem_rdata;

    logic [PIXEL_W-1:0]    hmask;
    logic                  match;
    logic [KW-1:0]         cnt_sum;

    always_comb
    begin
        int wi, hi, ni;
        wi = int'(width_reg);
        hi = int'(height_reg);
        ni = int'(wsize_reg);
        if (wi < 1) wi = 1;
        if (wi > MAX_WIDTH) wi = MAX_WIDTH;
        if (hi < 1) hi = 1;
        if (hi > MAX_HEIGHT) hi = MAX_HEIGHT;
        if (ni > MAX_WINDOW) ni = MAX_WINDOW;
        if (ni < 3) ni = 3;
        if ((ni % 2) == 0) ni = ni - 1;
        w_eff     = SW'(wi);
        h_eff     = SW'(hi);
        n_eff     = NW'(ni);
        p_eff     = SW'(ni / 2);
        cnt_total = KW'(ni * ni);
    end

    assign accept = (state_reg == S_IDLE) && pix.valid;

    always_comb
    begin
        logic signed [SW-1:0] c0, k0;
        c0 = SW'({1'b0, col_reg});
        k0 = SW'({1'b0, row_reg});
        if (c0 >= w_eff || k0 >= h_eff + p_eff)
        begin
            c_cur    = '0;
            k_cur    = '0;
            slot_cur = '0;
        end
        else
        begin
            c_cur    = c0;
            k_cur    = k0;
            slot_cur = slot_reg;
        end
        first_oc = c_cur - p_eff;
        last_oc  = c_cur - p_eff;
        if (c_cur == w_eff - 1)
        begin
            if (first_oc < 0) first_oc = '0;
            last_oc = w_eff - 1;
        end
        has_out = (k_cur >= p_eff) && (first_oc >= 0);
    end

    assign mem_we    = accept && (k_cur < h_eff);
    assign mem_waddr = AW'(int'(slot_cur) * MAX_WIDTH + int'(c_cur));
    assign mem_wdata = pix.func ? '0 : pix.pixel_value;

    always_comb
    begin
        logic signed [SW-1:0] rr, cc, sl;
        rr = r_reg + SW'({1'b0, dy_reg}) - p_eff;
        if (rr < 0) rr = '0;
        if (rr > h_eff - 1) rr = h_eff - 1;
        sl = SW'({1'b0, kslot_reg}) + (rr - k_reg);
        if (sl < 0) sl = sl + SW'(MAX_WINDOW);
        cc = oc_reg + SW'({1'b0, dx_reg}) - p_eff;
        if (cc < 0) cc = '0;
        if (cc > w_eff - 1) cc = w_eff - 1;
        mem_raddr = AW'(int'(sl) * MAX_WIDTH + int'(cc));
    end

    wmf_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign hmask   = PIXEL_W'(9'h1FF << (4'(bit_reg) + 4'd1));
    assign match   = rd_vld_reg && (((mem_rdata ^ prefix_reg) & hmask) == '0)
                     && !mem_rdata[bit_reg];
    assign cnt_sum = cnt0_reg + KW'(match);

    assign read_last = (dy_reg == n_eff - 1) && (dx_reg == n_eff - 1);
    assign pass_done = (state_reg == S_DRAIN) && (bit_reg == 3'd0);
    assign emit_done = (state_reg == S_EMIT) && res.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && has_out) state_next = S_READ;
            end
            S_READ:
            begin
                if (read_last) state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = pass_done ? S_EMIT : S_READ;
            end
            S_EMIT:
            begin
                if (res.ready) state_next = (oc_reg == last_reg) ? S_IDLE : S_READ;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        pix.ready        = (state_reg == S_IDLE);
        res.valid        = (state_reg == S_EMIT);
        res.median_value = prefix_reg;
        res.run_last     = (oc_reg == last_reg);
        res.frame_last   = (r_reg == h_eff - 1) && (oc_reg == w_eff - 1);
    end

    // datapath
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        slot_next   = slot_reg;
        r_next      = r_reg;
        k_next      = k_reg;
        kslot_next  = kslot_reg;
        oc_next     = oc_reg;
        last_next   = last_reg;
        dy_next     = dy_reg;
        dx_next     = dx_reg;
        bit_next    = bit_reg;
        prefix_next = prefix_reg;
        rank_next   = rank_reg;
        cnt0_next   = cnt_sum;
        if (accept)
        begin
            r_next     = k_cur - p_eff;
            k_next     = k_cur;
            kslot_next = slot_cur;
            oc_next    = first_oc;
            last_next  = last_oc;
            if (c_cur + 1 >= w_eff)
            begin
                col_next = '0;
                if (k_cur + 1 >= h_eff + p_eff)
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = RW'(k_cur + 1);
                    slot_next = (slot_cur == SLW'(MAX_WINDOW - 1)) ? '0 : slot_cur + 1'b1;
                end
            end
            else
            begin
                col_next  = CW'(c_cur + 1);
                row_next  = RW'(k_cur);
                slot_next = slot_cur;
            end
        end
        if (accept || emit_done)
        begin
            dy_next     = '0;
            dx_next     = '0;
            bit_next    = 3'd7;
            prefix_next = '0;
            rank_next   = cnt_total >> 1;
            cnt0_next   = '0;
            if (emit_done) oc_next = oc_reg + 1;
        end
        if (state_reg == S_READ)
        begin
            if (dx_reg == n_eff - 1)
            begin
                dx_next = '0;
                dy_next = dy_reg + 1'b1;
            end
            else
            begin
                dx_next = dx_reg + 1'b1;
            end
        end
        if (state_reg == S_DRAIN)
        begin
            dy_next   = '0;
            dx_next   = '0;
            cnt0_next = '0;
            if (cnt_sum <= rank_reg)
            begin
                prefix_next[bit_reg] = 1'b1;
                rank_next            = rank_reg - cnt_sum;
            end
            if (bit_reg != 3'd0) bit_next = bit_reg - 1'b1;
        end
        if (cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT
                       || cfg_index == REG_WINDOW_SIZE))
        begin
            col_next  = '0;
            row_next  = '0;
            slot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            width_reg  <= CFG_DATA_W'(512);
            height_reg <= CFG_DATA_W'(512);
            wsize_reg  <= WSIZE_W'(3);
            col_reg    <= '0;
            row_reg    <= '0;
            slot_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            slot_reg   <= slot_next;
            rd_vld_reg <= (state_reg == S_READ);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    REG_WINDOW_SIZE:  wsize_reg  <= cfg_data[WSIZE_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        k_reg      <= k_next;
        kslot_reg  <= kslot_next;
        oc_reg     <= oc_next;
        last_reg   <= last_next;
        dy_reg     <= dy_next;
        dx_reg     <= dx_next;
        bit_reg    <= bit_next;
        prefix_reg <= prefix_next;
        rank_reg   <= rank_next;
        cnt0_reg   <= cnt0_next;
    end

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == S_IDLE)
        else $error("line store written outside idle");

    a_drain_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN |-> $past(state_reg == S_READ))
        else $error("drain entered without a read pass");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> rank_reg < cnt_total)
        else $error("select rank out of window");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.ready && res.run_last |=> state_reg == S_IDLE)
        else $error("run end did not return to idle");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench of window_median_filter: random frames of pixel requests
// against an in-bench median predictor, with random idling on both channels.
// Depends on wmf_pkg, wmf_pix_if, wmf_res_if and the filter RTL.
`default_nettype none

module testbench;
    import wmf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DUMMY = 1'b1;
    localparam int LINE_ROWS = 9;
    localparam int LINE_LEN  = 512;
    localparam int ITEM_GOAL = 290;

    typedef struct packed {
        logic               func;
        logic [PIXEL_W-1:0] pixel_value;
    } pixel_req_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] median_value;
        logic               run_last;
        logic               frame_last;
    } median_req_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wmf_pix_if pix();
    wmf_res_if res();

    window_median_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix.sink),
        .res       (res.source)
    );

    pixel_req_t  pending_pixels[$];
    median_req_t medians_due[$];

    logic [9:0] width_reg;
    logic [9:0] height_reg;
    logic [3:0] wsize_reg;
    int         col_pos;
    int         row_pos;
    logic [PIXEL_W-1:0] line_store[LINE_ROWS][LINE_LEN];

    bit idle_on;
    bit px_fire;
    int gap_left;
    int stall_left;
    int mismatches;
    int medians_seen;
    int pixels_sent;
    int phases;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int frame_width();
        int v;
        v = int'(width_reg);
        if (v < 1) v = 1;
        if (v > LINE_LEN) v = LINE_LEN;
        return v;
    endfunction

    function automatic int frame_height();
        int v;
        v = int'(height_reg);
        if (v < 1) v = 1;
        if (v > 512) v = 512;
        return v;
    endfunction

    function automatic int kernel_side();
        int v;
        v = int'(wsize_reg);
        if (v > LINE_ROWS) v = LINE_ROWS;
        if (v < 3) v = 3;
        if (v % 2 == 0) v = v - 1;
        return v;
    endfunction

    function automatic logic [PIXEL_W-1:0] window_median(int r, int oc, int n, int w, int h);
        int hist[256];
        int p, rr, cc, total, acc, v;
        p = n / 2;
        total = n * n;
        foreach (hist[i]) hist[i] = 0;
        for (int dy = 0; dy < n; dy++) begin
            rr = r + dy - p;
            if (rr < 0) rr = 0;
            if (rr > h - 1) rr = h - 1;
            for (int dx = 0; dx < n; dx++) begin
                cc = oc + dx - p;
                if (cc < 0) cc = 0;
                if (cc > w - 1) cc = w - 1;
                hist[line_store[rr % LINE_ROWS][cc]]++;
            end
        end
        acc = 0;
        for (v = 0; v < 256; v++) begin
            acc += hist[v];
            if (acc > total / 2) break;
        end
        return v[PIXEL_W-1:0];
    endfunction

    function automatic void predict_medians(pixel_req_t req);
        int w, h, n, p, c, k, first, last, added;
        median_req_t m;
        w = frame_width();
        h = frame_height();
        n = kernel_side();
        p = n / 2;
        added = 0;
        if (col_pos >= w || row_pos >= h + p) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        k = row_pos;
        if (k < h)
            line_store[k % LINE_ROWS][c] = (req.func == FUNC_DUMMY) ? '0 : req.pixel_value;
        if (k >= p) begin
            first = c - p;
            last = c - p;
            if (c == w - 1) begin
                if (first < 0) first = 0;
                last = w - 1;
            end
            for (int oc = first; oc >= 0 && oc <= last; oc++) begin
                m.median_value = window_median(k - p, oc, n, w, h);
                m.run_last = 1'b0;
                m.frame_last = (k - p == h - 1 && oc == w - 1);
                medians_due.push_back(m);
                added++;
            end
            if (added > 0) medians_due[medians_due.size() - 1].run_last = 1'b1;
        end
        c++;
        if (c >= w) begin
            c = 0;
            k++;
            if (k >= h + p) k = 0;
        end
        col_pos = c;
        row_pos = k;
    endfunction

    always @(posedge clk) begin
        px_fire <= pix.valid && pix.ready;
        if (rst_n && pix.valid && pix.ready)
            predict_medians('{pix.func, pix.pixel_value});
    end

    always @(negedge clk) begin
        if (rst_n && (!pix.valid || px_fire)) begin
            if (gap_left > 0) begin
                pix.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_pixels.size() > 0 && idle_on && $urandom_range(0, 7) == 0) begin
                pix.valid <= 1'b0;
                gap_left <= $urandom_range(0, 11);
            end else if (pending_pixels.size() > 0) begin
                pixel_req_t nxt;
                nxt = pending_pixels.pop_front();
                pix.valid <= 1'b1;
                pix.func <= nxt.func;
                pix.pixel_value <= nxt.pixel_value;
            end else begin
                pix.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (stall_left > 0) begin
            res.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            res.ready <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            res.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && res.valid && res.ready) begin
            medians_seen++;
            if (medians_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected median %0d run_last %0b frame_last %0b",
                             res.median_value, res.run_last, res.frame_last);
            end else begin
                median_req_t exp_m;
                exp_m = medians_due.pop_front();
                if (res.median_value !== exp_m.median_value || res.run_last !== exp_m.run_last
                    || res.frame_last !== exp_m.frame_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("median mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                 exp_m.median_value, exp_m.run_last, exp_m.frame_last,
                                 res.median_value, res.run_last, res.frame_last);
                end
            end
        end
    end

    task automatic wait_drained();
        do begin
            @(negedge clk);
            #1;
        end while (pending_pixels.size() > 0 || pix.valid || medians_due.size() > 0);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  width_reg = val;
            REG_IMAGE_HEIGHT: height_reg = val;
            REG_WINDOW_SIZE:  wsize_reg = val[WSIZE_W-1:0];
            default: return;
        endcase
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic set_frame(int w, int h, int n);
        write_reg(REG_IMAGE_WIDTH, w[CFG_DATA_W-1:0]);
        write_reg(REG_IMAGE_HEIGHT, h[CFG_DATA_W-1:0]);
        write_reg(REG_WINDOW_SIZE, n[CFG_DATA_W-1:0]);
    endtask

    function automatic logic [PIXEL_W-1:0] rand_level();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
        return PIXEL_W'($urandom_range(0, 255));
    endfunction

    // queue up to max_items of a frame; padding rows get dummies, with some noise
    task automatic queue_frame(int max_items, output int queued);
        int w, h, p;
        pixel_req_t r;
        w = frame_width();
        h = frame_height();
        p = kernel_side() / 2;
        queued = 0;
        for (int k = 0; k < h + p && queued < max_items; k++)
            for (int c = 0; c < w && queued < max_items; c++) begin
                r.func = (k >= h) ? FUNC_DUMMY : FUNC_PIXEL;
                if ($urandom_range(0, 11) == 0) r.func = ~r.func;
                r.pixel_value = rand_level();
                pending_pixels.push_back(r);
                queued++;
            end
        pixels_sent += queued;
    endtask

    initial begin
        int got, nframes, lim;
        pixel_req_t r;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        pix.valid = 1'b0;
        pix.func = FUNC_PIXEL;
        pix.pixel_value = '0;
        res.ready = 1'b0;
        width_reg = 10'd512;
        height_reg = 10'd512;
        wsize_reg = 4'd3;
        col_pos = 0;
        row_pos = 0;
        foreach (line_store[i, j]) line_store[i][j] = '0;
        idle_on = 1'b1;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        set_frame(4, 3, 3);
        for (int i = 0; i < 16; i++) begin
            r.func = (i / 4 == 3) ? (i == 13 ? FUNC_PIXEL : FUNC_DUMMY)
                                  : (i == 5 ? FUNC_DUMMY : FUNC_PIXEL);
            r.pixel_value = (i % 3 == 0) ? 8'hff : (i % 3 == 1) ? 8'h00 : PIXEL_W'(i * 17);
            pending_pixels.push_back(r);
        end
        pixels_sent += 16;
        wait_drained();
        set_frame(0, 0, 15);
        write_reg(REG_UNUSED, 10'h3ff);
        queue_frame(7, got);
        wait_drained();
        set_frame(2, 2, 8);
        queue_frame(1000, got);
        wait_drained();
        set_frame(1023, 1, 3);
        queue_frame(40, got);
        wait_drained();
        set_frame(1, 512, 2);
        queue_frame(40, got);
        phases = 5;

        while (pixels_sent < ITEM_GOAL) begin
            wait_drained();
            phases++;
            if ($urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, 12)));
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 8)));
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_WINDOW_SIZE, CFG_DATA_W'($urandom_range(0, 15)));
                if ($urandom_range(0, 7) == 0)
                    write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 1023)));
            end
            nframes = $urandom_range(1, 2);
            for (int f = 0; f < nframes; f++) begin
                lim = ITEM_GOAL - pixels_sent;
                if (f == nframes - 1 && $urandom_range(0, 3) == 0 && lim > 40)
                    lim = int'($urandom_range(1, 40));
                if (lim > 0)
                    queue_frame(lim, got);
            end
        end

        wait_drained();
        idle_on = 1'b0;
        set_frame(5, 4, 5);
        queue_frame(1000, got);
        wait_drained();
        repeat (700) @(negedge clk);
        mismatches += medians_due.size();
        $display("ran %0d phases: %0d pixel requests, %0d medians checked, %0d mismatches",
                 phases, pixels_sent, medians_seen, mismatches);
        if (mismatches == 0)
            $display("** window_median_filter: PASSED **");
        else
            $display("** window_median_filter: FAILED **");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("timeout with %0d medians outstanding", medians_due.size());
        $display("** window_median_filter: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
